// ===== rtl/core/sik_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SCARA inverse kinematics package
// Shared constants, beat types, the arctangent table and small helper
// functions for the cell chains.
// ----------------------------------------------------------------------------
package sik_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 24;
  localparam int UNIT_BITS    = 30;
  localparam int DIV_CELLS    = UNIT_BITS;
  localparam int SQRT_CELLS   = UNIT_BITS + 1;
  localparam int DEG_SHIFT    = 32 - FRAC_BITS;
  localparam int LATENCY      = 6 + DIV_CELLS + 2 + SQRT_CELLS + 3 + CORDIC_STEPS + 6;
  localparam int TAIL_LEN     = CORDIC_STEPS + 6;
  localparam int ADDR_W       = 4;

  localparam logic signed [33:0] HALF_TURN = 34'sh0_8000_0000;
  localparam logic [44:0]        ROUND_ADD = 45'd1 << (DEG_SHIFT - 1);

  typedef enum logic [1:0] {
    REG_INNER  = 2'd0,
    REG_OUTER  = 2'd1,
    REG_BASE_X = 2'd2,
    REG_BASE_Y = 2'd3
  } reg_idx_t;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] TURN_ATAN [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
  } target_t;

  typedef struct packed {
    logic signed [31:0] support_arm_angle;
    logic signed [31:0] sub_arm_angle;
    logic signed [31:0] vertical_axis;
    logic               out_of_reach;
  } result_t;

  typedef struct packed {
    logic signed [32:0] sx;
    logic signed [32:0] sy;
    logic [29:0]        l1;
    logic [29:0]        l2;
    logic               neg;
    logic               oor;
    logic signed [31:0] z;
  } side_t;

  typedef struct packed {
    logic [61:0] rem;
    logic [60:0] d;
    logic [30:0] quo;
    side_t       side;
  } div_beat_t;

  typedef struct packed {
    logic [61:0] v;
    logic [61:0] res;
    logic [30:0] c;
    side_t       side;
  } sqrt_beat_t;

  typedef struct packed {
    logic signed [63:0] cx;
    logic signed [63:0] cy;
    logic signed [33:0] ang;
    logic               xneg;
    logic               yneg;
    logic               zero;
  } lane_t;

  typedef struct packed {
    logic               oor;
    logic signed [31:0] z;
  } tail_t;

  function automatic lane_t lane_prep(input logic signed [63:0] y,
                                      input logic signed [63:0] x);
    lane_t l;
    l.xneg = x[63];
    l.yneg = y[63];
    l.cx   = x[63] ? -x : x;
    l.cy   = y[63] ? -y : y;
    l.ang  = '0;
    l.zero = (x == 64'sd0) && (y == 64'sd0);
    return l;
  endfunction

  function automatic logic signed [33:0] lane_fix(input lane_t l);
    logic signed [33:0] a;
    a = l.ang;
    if (l.xneg) a = HALF_TURN - a;
    if (l.yneg) a = -a;
    if (l.zero) a = '0;
    return a;
  endfunction

  function automatic logic [31:0] sat_deg(input logic neg, input logic [44:0] prod);
    logic [44:0] m;
    logic [31:0] r;
    m = prod >> DEG_SHIFT;
    if (neg) begin
      if (m >= 45'h0_8000_0000) r = 32'h8000_0000;
      else                      r = 32'h0 - m[31:0];
    end else begin
      if (m > 45'h0_7FFF_FFFF)  r = 32'h7FFF_FFFF;
      else                      r = m[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/scara_inverse_kinematics_top.sv =====
`default_nettype none
// A result strobes on done once its start beat has run through every pipeline register.
// Throughput: one point per cycle; busy stays low and the result is never held.
// The depth is set by the division, square root and CORDIC cell chains.
// Reset: arm lengths return to 200 mm, base offsets to zero, points in flight drop.
// ----------------------------------------------------------------------------
// SCARA inverse kinematics top
// Target point in, joint angles out, through chains of arithmetic cells.
// ----------------------------------------------------------------------------
module scara_inverse_kinematics_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire sik_pkg::target_t             target,
  output logic                              done,
  output sik_pkg::result_t                  result,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sik_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [30:0]        inner_len;
  logic [30:0]        outer_len;
  logic signed [31:0] base_x;
  logic signed [31:0] base_y;
  logic [sik_pkg::LATENCY-1:0] vld;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign done   = vld[sik_pkg::LATENCY-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_len <= 31'd13107200;
      outer_len <= 31'd13107200;
      base_x    <= '0;
      base_y    <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (sik_pkg::reg_idx_t'(paddr[3:2]))
        sik_pkg::REG_INNER:  inner_len <= pwdata[30:0];
        sik_pkg::REG_OUTER:  outer_len <= pwdata[30:0];
        sik_pkg::REG_BASE_X: base_x    <= pwdata;
        sik_pkg::REG_BASE_Y: base_y    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sik_pkg::reg_idx_t'(paddr[3:2]))
      sik_pkg::REG_INNER:  prdata = {1'b0, inner_len};
      sik_pkg::REG_OUTER:  prdata = {1'b0, outer_len};
      sik_pkg::REG_BASE_X: prdata = base_x;
      sik_pkg::REG_BASE_Y: prdata = base_y;
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[sik_pkg::LATENCY-2:0], start & ~busy};
    end
  end

  // offsets
  logic signed [32:0] s1_sx, s1_sy;
  logic signed [31:0] s1_z;

  always_ff @(posedge clk) begin
    s1_sx <= {target.target_x[31], target.target_x} - {base_x[31], base_x};
    s1_sy <= {target.target_y[31], target.target_y} - {base_y[31], base_y};
    s1_z  <= target.target_z;
  end

  // common normalizing shift
  logic [32:0] ax, ay;
  logic [1:0]  nsh;
  logic [29:0] s2_ax, s2_ay, s2_l1, s2_l2;
  logic signed [32:0] s2_sx, s2_sy;
  logic signed [31:0] s2_z;

  assign ax = s1_sx[32] ? 33'(-s1_sx) : 33'(s1_sx);
  assign ay = s1_sy[32] ? 33'(-s1_sy) : 33'(s1_sy);

  always_comb begin
    priority if (ax[32] || ay[32])                             nsh = 2'd3;
    else if (ax[31] || ay[31])                                 nsh = 2'd2;
    else if (ax[30] || ay[30] || inner_len[30] || outer_len[30]) nsh = 2'd1;
    else                                                       nsh = 2'd0;
  end

  always_ff @(posedge clk) begin
    s2_ax <= 30'(ax >> nsh);
    s2_ay <= 30'(ay >> nsh);
    s2_l1 <= 30'(inner_len >> nsh);
    s2_l2 <= 30'(outer_len >> nsh);
    s2_sx <= s1_sx;
    s2_sy <= s1_sy;
    s2_z  <= s1_z;
  end

  // squares
  logic [59:0] s3_axx, s3_ayy, s3_l11, s3_l22, s3_l12;
  logic [29:0] s3_l1, s3_l2;
  logic signed [32:0] s3_sx, s3_sy;
  logic signed [31:0] s3_z;

  always_ff @(posedge clk) begin
    s3_axx <= s2_ax * s2_ax;
    s3_ayy <= s2_ay * s2_ay;
    s3_l11 <= s2_l1 * s2_l1;
    s3_l22 <= s2_l2 * s2_l2;
    s3_l12 <= s2_l1 * s2_l2;
    s3_l1  <= s2_l1;
    s3_l2  <= s2_l2;
    s3_sx  <= s2_sx;
    s3_sy  <= s2_sy;
    s3_z   <= s2_z;
  end

  logic [60:0] s4_r2, s4_q, s4_d;
  logic [29:0] s4_l1, s4_l2;
  logic signed [32:0] s4_sx, s4_sy;
  logic signed [31:0] s4_z;

  always_ff @(posedge clk) begin
    s4_r2 <= {1'b0, s3_axx} + {1'b0, s3_ayy};
    s4_q  <= {1'b0, s3_l11} + {1'b0, s3_l22};
    s4_d  <= {s3_l12, 1'b0};
    s4_l1 <= s3_l1;
    s4_l2 <= s3_l2;
    s4_sx <= s3_sx;
    s4_sy <= s3_sy;
    s4_z  <= s3_z;
  end

  logic [60:0] s5_n, s5_d;
  logic        s5_neg;
  logic [29:0] s5_l1, s5_l2;
  logic signed [32:0] s5_sx, s5_sy;
  logic signed [31:0] s5_z;

  always_ff @(posedge clk) begin
    s5_neg <= s4_r2 < s4_q;
    s5_n   <= (s4_r2 < s4_q) ? s4_q - s4_r2 : s4_r2 - s4_q;
    s5_d   <= s4_d;
    s5_l1  <= s4_l1;
    s5_l2  <= s4_l2;
    s5_sx  <= s4_sx;
    s5_sy  <= s4_sy;
    s5_z   <= s4_z;
  end

  // elbow cosine divider
  sik_pkg::div_beat_t div_q [sik_pkg::DIV_CELLS+1];
  logic c0;

  assign c0 = s5_n == s5_d;

  always_ff @(posedge clk) begin
    div_q[0].rem       <= c0 ? 62'd0 : {1'b0, s5_n};
    div_q[0].d         <= s5_d;
    div_q[0].quo       <= {30'd0, c0};
    div_q[0].side.sx   <= s5_sx;
    div_q[0].side.sy   <= s5_sy;
    div_q[0].side.l1   <= s5_l1;
    div_q[0].side.l2   <= s5_l2;
    div_q[0].side.neg  <= s5_neg;
    div_q[0].side.oor  <= (s5_d == 61'd0) || (s5_n > s5_d);
    div_q[0].side.z    <= s5_z;
  end

  for (genvar i = 0; i < sik_pkg::DIV_CELLS; i++) begin : g_div
    sik_div_cell u_cell (
      .clk  (clk),
      .din  (div_q[i]),
      .dout (div_q[i+1])
    );
  end

  // elbow sine
  logic [30:0]   s7_c;
  logic [61:0]   s7_cc;
  sik_pkg::side_t s7_side;
  sik_pkg::sqrt_beat_t sq_q [sik_pkg::SQRT_CELLS+1];

  always_ff @(posedge clk) begin
    s7_c    <= div_q[sik_pkg::DIV_CELLS].quo;
    s7_cc   <= div_q[sik_pkg::DIV_CELLS].quo * div_q[sik_pkg::DIV_CELLS].quo;
    s7_side <= div_q[sik_pkg::DIV_CELLS].side;
  end

  always_ff @(posedge clk) begin
    sq_q[0].v    <= (62'd1 << (2 * sik_pkg::UNIT_BITS)) - s7_cc;
    sq_q[0].res  <= '0;
    sq_q[0].c    <= s7_c;
    sq_q[0].side <= s7_side;
  end

  for (genvar j = 0; j < sik_pkg::SQRT_CELLS; j++) begin : g_sqrt
    sik_sqrt_cell u_cell (
      .clk  (clk),
      .k    (5'(sik_pkg::SQRT_CELLS - 1 - j)),
      .din  (sq_q[j]),
      .dout (sq_q[j+1])
    );
  end

  // arctangent operands
  logic [60:0]    s9_pa, s9_pb;
  logic [30:0]    s9_s, s9_c;
  sik_pkg::side_t s9_side;

  always_ff @(posedge clk) begin
    s9_s    <= sq_q[sik_pkg::SQRT_CELLS].res[30:0];
    s9_c    <= sq_q[sik_pkg::SQRT_CELLS].c;
    s9_pa   <= sq_q[sik_pkg::SQRT_CELLS].side.l2 * sq_q[sik_pkg::SQRT_CELLS].c;
    s9_pb   <= sq_q[sik_pkg::SQRT_CELLS].side.l2 * sq_q[sik_pkg::SQRT_CELLS].res[30:0];
    s9_side <= sq_q[sik_pkg::SQRT_CELLS].side;
  end

  logic signed [61:0] s10_sk1, s10_sk2;
  logic signed [31:0] s10_cs;
  logic [30:0]        s10_s;
  logic signed [32:0] s10_sx, s10_sy;
  sik_pkg::tail_t     s10_tail;
  logic [61:0]        l1w;

  assign l1w = {2'b00, s9_side.l1, 30'd0};

  always_ff @(posedge clk) begin
    s10_sk1  <= s9_side.neg ? l1w - {1'b0, s9_pa} : l1w + {1'b0, s9_pa};
    s10_sk2  <= {1'b0, s9_pb};
    s10_cs   <= s9_side.neg ? -$signed({1'b0, s9_c}) : $signed({1'b0, s9_c});
    s10_s    <= s9_s;
    s10_sx   <= s9_side.sx;
    s10_sy   <= s9_side.sy;
    s10_tail <= {s9_side.oor, s9_side.z};
  end

  // three CORDIC lanes
  sik_pkg::lane_t lane_a [sik_pkg::CORDIC_STEPS+1];
  sik_pkg::lane_t lane_b [sik_pkg::CORDIC_STEPS+1];
  sik_pkg::lane_t lane_c [sik_pkg::CORDIC_STEPS+1];
  sik_pkg::tail_t tail_q [sik_pkg::TAIL_LEN];

  always_ff @(posedge clk) begin
    lane_a[0] <= sik_pkg::lane_prep({{2{s10_sk1[61]}}, s10_sk1},
                                    {{2{s10_sk2[61]}}, s10_sk2});
    lane_b[0] <= sik_pkg::lane_prep({{31{s10_sx[32]}}, s10_sx},
                                    {{31{s10_sy[32]}}, s10_sy});
    lane_c[0] <= sik_pkg::lane_prep({33'd0, s10_s}, {{32{s10_cs[31]}}, s10_cs});
    tail_q[0] <= s10_tail;
    for (int t = 1; t < sik_pkg::TAIL_LEN; t++) begin
      tail_q[t] <= tail_q[t-1];
    end
  end

  for (genvar i = 0; i < sik_pkg::CORDIC_STEPS; i++) begin : g_cordic
    sik_cordic_cell u_a (.clk(clk), .step(5'(i)), .din(lane_a[i]), .dout(lane_a[i+1]));
    sik_cordic_cell u_b (.clk(clk), .step(5'(i)), .din(lane_b[i]), .dout(lane_b[i+1]));
    sik_cordic_cell u_c (.clk(clk), .step(5'(i)), .din(lane_c[i]), .dout(lane_c[i+1]));
  end

  // angle assembly and degree conversion
  logic signed [33:0] p1_a, p1_b, p1_c, p2_psi;
  logic signed [35:0] p2_th, p3_th, p3_tp;
  logic               p4_nt, p4_np;
  logic [35:0]        p4_mt, p4_mp;
  logic               p5_nt, p5_np;
  logic [44:0]        p5_pt, p5_pp;
  sik_pkg::tail_t     tl;

  assign tl = tail_q[sik_pkg::TAIL_LEN-1];

  always_ff @(posedge clk) begin
    p1_a   <= sik_pkg::lane_fix(lane_a[sik_pkg::CORDIC_STEPS]);
    p1_b   <= sik_pkg::lane_fix(lane_b[sik_pkg::CORDIC_STEPS]);
    p1_c   <= sik_pkg::lane_fix(lane_c[sik_pkg::CORDIC_STEPS]);
    p2_th  <= {{2{p1_a[33]}}, p1_a} - {{2{p1_b[33]}}, p1_b};
    p2_psi <= p1_c;
    p3_th  <= p2_th;
    p3_tp  <= p2_th + {{2{p2_psi[33]}}, p2_psi};
    p4_nt  <= p3_th[35];
    p4_np  <= p3_tp[35];
    p4_mt  <= p3_th[35] ? 36'(-p3_th) : 36'(p3_th);
    p4_mp  <= p3_tp[35] ? 36'(-p3_tp) : 36'(p3_tp);
    p5_nt  <= p4_nt;
    p5_np  <= p4_np;
    p5_pt  <= {9'd0, p4_mt} * 45'd360 + sik_pkg::ROUND_ADD;
    p5_pp  <= {9'd0, p4_mp} * 45'd360 + sik_pkg::ROUND_ADD;
  end

  always_ff @(posedge clk) begin
    result.support_arm_angle <= tl.oor ? 32'sd0 : $signed(sik_pkg::sat_deg(p5_nt, p5_pt));
    result.sub_arm_angle     <= tl.oor ? 32'sd0 : $signed(sik_pkg::sat_deg(p5_np, p5_pp));
    result.vertical_axis     <= tl.z;
    result.out_of_reach      <= tl.oor;
  end

`ifndef SYNTH
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, sik_pkg::LATENCY))
    else $error("result beat without a start beat");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.out_of_reach |->
      result.support_arm_angle == 32'sd0 && result.sub_arm_angle == 32'sd0)
    else $error("out of reach beat carries nonzero angles");

  a_z_through: assert property (@(posedge clk) disable iff (rst)
    done |-> result.vertical_axis == $past(target.target_z, sik_pkg::LATENCY))
    else $error("vertical axis does not match its start beat");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/sik_div_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Division cell
// One restoring quotient bit per cell for the elbow cosine.
// ----------------------------------------------------------------------------
module sik_div_cell (
  input  wire logic                clk,
  input  wire sik_pkg::div_beat_t  din,
  output sik_pkg::div_beat_t       dout
);

  logic [61:0] sh;
  logic        take;

  assign sh   = {din.rem[60:0], 1'b0};
  assign take = sh >= {1'b0, din.d};

  always_ff @(posedge clk) begin
    dout.rem  <= take ? sh - {1'b0, din.d} : sh;
    dout.d    <= din.d;
    dout.quo  <= {din.quo[29:0], take};
    dout.side <= din.side;
  end

endmodule
`default_nettype wire

// ===== rtl/core/sik_sqrt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Square root cell
// One result bit per cell of the floor square root for the elbow sine.
// ----------------------------------------------------------------------------
module sik_sqrt_cell (
  input  wire logic                clk,
  input  wire logic [4:0]          k,
  input  wire sik_pkg::sqrt_beat_t din,
  output sik_pkg::sqrt_beat_t      dout
);

  logic [61:0] bitv;
  logic [61:0] trial;
  logic        take;

  assign bitv  = 62'd1 << {k, 1'b0};
  assign trial = din.res + bitv;
  assign take  = din.v >= trial;

  always_ff @(posedge clk) begin
    dout.v    <= take ? din.v - trial : din.v;
    dout.res  <= take ? (din.res >> 1) + bitv : din.res >> 1;
    dout.c    <= din.c;
    dout.side <= din.side;
  end

endmodule
`default_nettype wire

// ===== rtl/core/sik_cordic_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// CORDIC cell
// One vectoring micro-rotation per cell, angle kept in 2^-32 turn.
// ----------------------------------------------------------------------------
module sik_cordic_cell (
  input  wire logic            clk,
  input  wire logic [4:0]      step,
  input  wire sik_pkg::lane_t  din,
  output sik_pkg::lane_t       dout
);

  logic signed [63:0] dx;
  logic signed [63:0] dy;
  logic signed [33:0] da;
  logic               rot;

  assign dx  = din.cy >>> step;
  assign dy  = din.cx >>> step;
  assign da  = $signed({2'b00, sik_pkg::TURN_ATAN[step]});
  assign rot = !din.cy[63];

  always_ff @(posedge clk) begin
    dout.cx   <= rot ? din.cx + dx : din.cx - dx;
    dout.cy   <= rot ? din.cy - dy : din.cy + dy;
    dout.ang  <= rot ? din.ang + da : din.ang - da;
    dout.xneg <= din.xneg;
    dout.yneg <= din.yneg;
    dout.zero <= din.zero;
  end

endmodule
`default_nettype wire

// ===== test/scara_inverse_kinematics_top_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SCARA inverse kinematics testbench
// Drives target points through the command port and checks every result
// against a bit-accurate fixed-point predictor of the arm solution, across
// several arm lengths and base offsets written over the register port.
// ----------------------------------------------------------------------------
module scara_inverse_kinematics_top_test;

  localparam int MAX_CYCLES = 400000;

  class joint_scoreboard;
    longint unsigned inner_len, outer_len;
    longint base_x, base_y;
    sik_pkg::result_t pending[$];
    int mismatches, results_seen, unreachable_seen;

    function void set_reg(sik_pkg::reg_idx_t idx, logic [31:0] v);
      case (idx)
        sik_pkg::REG_INNER:  inner_len = v[30:0];
        sik_pkg::REG_OUTER:  outer_len = v[30:0];
        sik_pkg::REG_BASE_X: base_x = longint'(signed'(v));
        sik_pkg::REG_BASE_Y: base_y = longint'(signed'(v));
      endcase
    endfunction

    function longint unsigned abs64(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    function longint arith_shr(longint v, int k);
      return v >>> k;
    endfunction

    function longint turn_angle(longint y, longint x);
      longint cx, cy, z, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      cx = abs64(x);
      cy = abs64(y);
      for (int i = 0; i < sik_pkg::CORDIC_STEPS && i < 32; i++) begin
        dx = arith_shr(cy, i);
        dy = arith_shr(cx, i);
        if (cy >= 0) begin
          cx += dx; cy -= dy; z += longint'(sik_pkg::TURN_ATAN[i]);
        end else begin
          cx -= dx; cy += dy; z -= longint'(sik_pkg::TURN_ATAN[i]);
        end
      end
      if (x < 0) z = (64'sd1 <<< 31) - z;
      if (y < 0) z = -z;
      return z;
    endfunction

    function logic [31:0] degrees(longint a);
      longint unsigned m;
      m = abs64(a) * 360;
      m = (m + (64'd1 << (sik_pkg::DEG_SHIFT - 1))) >> sik_pkg::DEG_SHIFT;
      if (a < 0) return m >= 64'h8000_0000 ? 32'h8000_0000 : 32'(64'h1_0000_0000 - m);
      return m > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : m[31:0];
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else res >>= 1;
        b >>= 2;
      end
      return res;
    endfunction

    function void note_target(sik_pkg::target_t t);
      sik_pkg::result_t r;
      longint sx, sy, cs, sk1, sk2, theta, psi;
      longint unsigned ax, ay, l1, l2, m, r2, q, d, n, rem, c, s;
      int sh;
      bit neg;
      sx = longint'(t.target_x) - base_x;
      sy = longint'(t.target_y) - base_y;
      ax = abs64(sx); ay = abs64(sy);
      l1 = inner_len; l2 = outer_len;
      m = ax;
      if (ay > m) m = ay;
      if (l1 > m) m = l1;
      if (l2 > m) m = l2;
      sh = 0;
      while ((m >> sh) >= (64'd1 << 30)) sh++;
      ax >>= sh; ay >>= sh; l1 >>= sh; l2 >>= sh;
      r2 = ax * ax + ay * ay;
      q = l1 * l1 + l2 * l2;
      d = 2 * l1 * l2;
      neg = r2 < q;
      n = neg ? q - r2 : r2 - q;
      r = '0;
      r.vertical_axis = t.target_z;
      if (d == 0 || n > d) begin
        r.out_of_reach = 1'b1;
      end else begin
        rem = n;
        c = 0;
        if (rem >= d) begin c = 1; rem -= d; end
        for (int i = 0; i < sik_pkg::UNIT_BITS; i++) begin
          rem <<= 1;
          c <<= 1;
          if (rem >= d) begin c |= 1; rem -= d; end
        end
        s = root_floor((64'd1 << (2 * sik_pkg::UNIT_BITS)) - c * c);
        cs = neg ? -longint'(c) : longint'(c);
        sk1 = longint'(l1 << sik_pkg::UNIT_BITS) + longint'(l2) * cs;
        sk2 = longint'(l2 * s);
        theta = turn_angle(sk1, sk2) - turn_angle(sx, sy);
        psi = turn_angle(longint'(s), cs);
        r.support_arm_angle = degrees(theta);
        r.sub_arm_angle = degrees(theta + psi);
      end
      pending.push_back(r);
    endfunction

    function void check_result(sik_pkg::result_t got);
      sik_pkg::result_t exp_r;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got.out_of_reach) unreachable_seen++;
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp %h %h %h %b got %h %h %h %b",
                   exp_r.support_arm_angle, exp_r.sub_arm_angle, exp_r.vertical_axis,
                   exp_r.out_of_reach, got.support_arm_angle, got.sub_arm_angle,
                   got.vertical_axis, got.out_of_reach);
      end
    endfunction
  endclass

  logic clk, rst, start, busy, done, psel, penable, pwrite, pready;
  logic [sik_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  sik_pkg::target_t target;
  sik_pkg::result_t result;
  joint_scoreboard board;
  int cycles, idle_pct;

  scara_inverse_kinematics_top DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) board.check_result(result);
    if (cycles > MAX_CYCLES) begin
      $display("timeout");
      $display("** scara_inverse_kinematics_top: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(sik_pkg::reg_idx_t idx, logic [31:0] v);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.set_reg(idx, v);
  endtask

  // enter and leave just after a falling edge; start stays high between beats unless idle cycles are drawn
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    start <= 1;
    target <= '{x, y, z};
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_target(target);
    @(negedge clk);
  endtask

  task automatic drain;
    start <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (sik_pkg::LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int unsigned lim);
    int v;
    v = int'($urandom_range(2 * lim)) - int'(lim);
    return 32'(v);
  endfunction

  task automatic random_phase(int n, int unsigned reach);
    logic [31:0] x, y;
    for (int i = 0; i < n; i++) begin
      idle_pct = (i > n / 3 && i < n / 2) ? 0 : 14;
      if ($urandom_range(9) == 0) begin
        x = $urandom; y = $urandom;
      end else begin
        x = 32'(longint'(signed'(rand_coord(reach))) + board.base_x);
        y = 32'(longint'(signed'(rand_coord(reach))) + board.base_y);
      end
      send_point(x, y, $urandom);
    end
  endtask

  initial begin
    board = new();
    board.set_reg(sik_pkg::REG_INNER, 32'd13107200);
    board.set_reg(sik_pkg::REG_OUTER, 32'd13107200);
    board.set_reg(sik_pkg::REG_BASE_X, 0);
    board.set_reg(sik_pkg::REG_BASE_Y, 0);
    cycles = 0; idle_pct = 14;
    rst = 1; start = 0; target = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send_point(32'd13107200, 32'd13107200, 32'h7FFF_FFFF);
    send_point(32'd26214400, 0, 32'h8000_0000);
    send_point(0, 32'd26214400, 32'hFFFF_FFFF);
    send_point(0, 0, 0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1234_5678);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h5555_5555);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA);
    send_point(32'hFE70_0000, 32'h0000_0001, 0);
    send_point(32'hFF38_0000, 32'hFF38_0000, 1);
    send_point(32'd26214400, 32'd1, 2);
    random_phase(200, 32'd30000000);
    drain();

    write_reg(sik_pkg::REG_INNER, 32'hFFFF_FFFF);
    write_reg(sik_pkg::REG_OUTER, 32'd65536);
    write_reg(sik_pkg::REG_BASE_X, 32'h8000_0000);
    write_reg(sik_pkg::REG_BASE_Y, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 3);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 4);
    random_phase(150, 32'h7FFF_0000);
    drain();

    write_reg(sik_pkg::REG_INNER, 32'd65536);
    write_reg(sik_pkg::REG_OUTER, 32'h7FFF_FFFF);
    write_reg(sik_pkg::REG_BASE_X, 32'h0010_0000);
    write_reg(sik_pkg::REG_BASE_Y, 32'hFFF0_0000);
    random_phase(150, 32'h7FFF_0000);
    drain();

    write_reg(sik_pkg::REG_INNER, 32'd9830400);
    write_reg(sik_pkg::REG_OUTER, 32'd6553600);
    write_reg(sik_pkg::REG_BASE_X, 32'hFFCE_0000);
    write_reg(sik_pkg::REG_BASE_Y, 32'd3276800);
    random_phase(300, 32'd18000000);
    drain();

    $display("covered %0d results, %0d out of reach, four register settings",
             board.results_seen, board.unreachable_seen);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("** scara_inverse_kinematics_top: PASSED **");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("** scara_inverse_kinematics_top: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
